// ----- rtl/gcr_pkg.sv -----
// Shared types and constants for the per-read FASTQ GC content block.
package gcr_pkg;

    // Sizing
    localparam int MAX_READ_LENGTH = 65535;
    localparam int FRACTION_BITS   = 16;
    localparam int TALLY_W         = 16;
    localparam int TALLY_MAX       = (1 << TALLY_W) - 1;
    localparam int FRAC_W          = FRACTION_BITS + 1;
    localparam int REM_W           = TALLY_W + 1;
    localparam int STEP_W          = $clog2(FRAC_W);
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W          = $clog2(QUEUE_DEPTH + 1);

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = 2 * TALLY_W + FRAC_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    // Base counters stop here
    localparam logic [TALLY_W-1:0] TALLY_LIMIT =
        TALLY_W'((MAX_READ_LENGTH > TALLY_MAX) ? TALLY_MAX : MAX_READ_LENGTH);

    // Character codes
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_C       = 8'h43;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_N       = 8'h4E;
    localparam logic [7:0] CHAR_T       = 8'h54;

    // Line inside a four-line record
    localparam logic [1:0] LINE_HEADER   = 2'd0;
    localparam logic [1:0] LINE_SEQUENCE = 2'd1;

    // One finished sequence line waiting for its fraction
    typedef struct packed {
        logic [TALLY_W-1:0] gc;
        logic [TALLY_W-1:0] bases;
        logic               saturated;
    } gcr_job_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic              full;
        logic              empty;
    } gcr_q_status_t;

endpackage

// ----- rtl/fastq_gc_content_per_read.sv -----
// Top level of the per-read FASTQ GC content block.
//
//   Channel | Ports              | Direction | Carries
//   --------+--------------------+-----------+--------------------------------------
//   input   | s_tvalid/tready    | in        | tdata[7:0] data_byte, tlast end_of_input
//   result  | m_tvalid/tready    | out       | tdata gc/base/fraction, tuser flags
//
// Text bytes are taken at up to one per cycle; the line counter never waits on the
// divider unless the four-entry job queue is full. The divider loads each sequence
// line result, works out its 17 quotient bits, then holds it for output until it is
// taken; a line with no bases skips the quotient bits. Reset is synchronous, active
// low, and clears the line position, tallies, queue and divider state. A stalled
// result holds in the output register while the front keeps counting.
module fastq_gc_content_per_read
    import gcr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // end_of_input
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [15:0] gc_count, [31:16] base_count,
                                              // [48:32] gc_fraction, [55:49] zero
    output logic [OUT_TUSER_W-1:0] m_tuser    // [0] no_bases, [1] count_saturated
);

    gcr_q_status_t q_status;
    gcr_job_t      push_job;
    gcr_job_t      pop_job;
    logic          push;
    logic          pop;

    gcr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    gcr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    gcr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // Input stalls only when the job queue is full
    a_ready_tracks_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_status.full)
        else $error("input stalled with room in the job queue");

    // A result is never pushed into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("job pushed into a full queue");

    // Empty line reports a zero fraction
    a_empty_fraction: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[48:32] == '0))
        else $error("baseless line with nonzero fraction");

    // GC count never exceeds the base count
    a_gc_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] <= m_tdata[31:16]))
        else $error("gc count above base count");
`endif

endmodule

// ----- rtl/gcr_front.sv -----
// Front part: tracks record lines and counts bases on the sequence line.
module gcr_front
    import gcr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // end_of_input
    input  gcr_q_status_t         q_status,
    output logic                  push,
    output gcr_job_t              push_job
);

    logic [1:0]         line_reg,  line_next;
    logic [TALLY_W-1:0] gc_reg,    gc_next;
    logic [TALLY_W-1:0] base_reg,  base_next;
    logic               sat_reg,   sat_next;

    logic               accept;
    logic               is_nl;
    logic               is_gc;
    logic               is_base;
    logic               on_seq;
    logic [TALLY_W-1:0] cnt_gc;
    logic [TALLY_W-1:0] cnt_base;
    logic               cnt_sat;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // Classify the byte and update the running tallies
    always_comb begin
        is_nl   = (s_tdata == CHAR_NEWLINE);
        is_gc   = (s_tdata == CHAR_G) || (s_tdata == CHAR_C);
        is_base = is_gc || (s_tdata == CHAR_A) || (s_tdata == CHAR_T) ||
                  (s_tdata == CHAR_N);
        on_seq  = (line_reg == LINE_SEQUENCE);

        cnt_gc   = gc_reg;
        cnt_base = base_reg;
        cnt_sat  = sat_reg;
        if (on_seq && is_base && !is_nl) begin
            if (base_reg >= TALLY_LIMIT) begin
                cnt_sat = 1'b1;
            end else begin
                cnt_base = base_reg + TALLY_W'(1);
                cnt_gc   = gc_reg + TALLY_W'(is_gc);
            end
        end

        push               = accept && on_seq && (is_nl || s_tlast);
        push_job.gc        = cnt_gc;
        push_job.bases     = cnt_base;
        push_job.saturated = cnt_sat;

        line_next = line_reg;
        gc_next   = gc_reg;
        base_next = base_reg;
        sat_next  = sat_reg;
        if (accept) begin
            if (s_tlast) begin
                line_next = LINE_HEADER;
                gc_next   = '0;
                base_next = '0;
                sat_next  = 1'b0;
            end else if (is_nl) begin
                line_next = line_reg + 2'd1;
                gc_next   = '0;
                base_next = '0;
                sat_next  = 1'b0;
            end else begin
                gc_next   = cnt_gc;
                base_next = cnt_base;
                sat_next  = cnt_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= LINE_HEADER;
            gc_reg   <= '0;
            base_reg <= '0;
            sat_reg  <= 1'b0;
        end else begin
            line_reg <= line_next;
            gc_reg   <= gc_next;
            base_reg <= base_next;
            sat_reg  <= sat_next;
        end
    end

endmodule

// ----- rtl/gcr_queue.sv -----
// Short job queue between the line counter and the divider.
module gcr_queue
    import gcr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gcr_job_t      push_job,
    input  logic          pop,
    output gcr_job_t      pop_job,
    output gcr_q_status_t q_status
);

    gcr_job_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QLVL_W-1:0] lvl_reg, lvl_next;
    logic              do_push;
    logic              do_pop;

    assign q_status.full  = (lvl_reg == QLVL_W'(QUEUE_DEPTH));
    assign q_status.empty = (lvl_reg == '0);
    assign pop_job        = slot_reg[rd_reg];

    // Pointer and level update
    always_comb begin
        do_push  = push && !q_status.full;
        do_pop   = pop && !q_status.empty;
        wr_next  = do_push ? wr_reg + QPTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + QPTR_W'(1) : rd_reg;
        lvl_next = lvl_reg;
        if (do_push && !do_pop) begin
            lvl_next = lvl_reg + QLVL_W'(1);
        end else if (do_pop && !do_push) begin
            lvl_next = lvl_reg - QLVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            lvl_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            lvl_reg <= lvl_next;
        end
    end

    // Payload slots
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/gcr_back.sv -----
// Back part: bit-serial GC fraction divider and result register.
module gcr_back
    import gcr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gcr_q_status_t          q_status,
    input  gcr_job_t               pop_job,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // [15:0] gc_count, [31:16] base_count,
                                             // [48:32] gc_fraction, [55:49] zero
    output logic [OUT_TUSER_W-1:0] m_tuser   // [0] no_bases, [1] count_saturated
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

    state_t             state_reg, state_next;
    gcr_job_t           job_reg,   job_next;
    logic [REM_W-1:0]   rem_reg,   rem_next;
    logic [FRAC_W-1:0]  quo_reg,   quo_next;
    logic [STEP_W-1:0]  step_reg,  step_next;

    logic [REM_W-1:0]   divisor;
    logic [REM_W-1:0]   diff;
    logic               ge;
    logic [REM_W-1:0]   kept;

    // One quotient bit per cycle, restoring division
    always_comb begin
        divisor = {1'b0, job_reg.bases};
        ge      = (rem_reg >= divisor);
        diff    = rem_reg - divisor;
        kept    = ge ? diff : rem_reg;

        pop        = (state_reg == ST_IDLE) && !q_status.empty;
        state_next = state_reg;
        job_next   = job_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    job_next   = pop_job;
                    rem_next   = {1'b0, pop_job.gc};
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (job_reg.bases == '0) begin
                    quo_next   = '0;
                    state_next = ST_HOLD;
                end else begin
                    quo_next  = {quo_reg[FRAC_W-2:0], ge};
                    rem_next  = {kept[TALLY_W-1:0], 1'b0};
                    step_next = step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(FRAC_W - 1)) begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        job_reg  <= job_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    // Result stream
    assign m_tvalid = (state_reg == ST_HOLD);
    assign m_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), quo_reg, job_reg.bases, job_reg.gc};
    assign m_tuser  = {job_reg.saturated, (job_reg.bases == '0)};

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Stream testbench for the per-read FASTQ GC content block, self-checking against its own predictor.
module testbench;
    import gcr_pkg::*;

    localparam int CYCLE_LIMIT      = 200_000;
    localparam int RANDOM_BYTES     = 850;
    localparam int PAUSE_AFTER      = 600;
    localparam int HOLD_AT_READ     = 10;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 64;
    localparam int MAX_PRINTED      = 50;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    // One read summary as it leaves the block
    typedef struct packed {
        logic [TALLY_W-1:0] gc;
        logic [TALLY_W-1:0] bases;
        logic [FRAC_W-1:0]  frac;
        logic               no_bases;
        logic               saturated;
    } read_gc_t;

    // One directed text byte; typed rows carry their expected summary
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        read_gc_t   want;
    } text_row_t;

    typedef enum logic [1:0] {READY_ALWAYS, READY_PATTERN, READY_SPARSE} ready_mode_t;

    localparam read_gc_t NO_READ = '0;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    // Predictor state: record line and running tallies of the sequence line
    logic [1:0]         line_pos;
    logic [TALLY_W-1:0] seq_gc;
    logic [TALLY_W-1:0] seq_bases;
    logic               seq_dropped;

    read_gc_t    pending_reads[$];
    read_gc_t    seen;
    read_gc_t    head;
    int          error_count;
    int          results_seen;
    int          bytes_sent;
    int          burst_left;
    int          cycle_count;
    int          start_bytes;
    int          i;
    logic        pause_done;
    logic        hold_done;
    ready_mode_t ready_mode;
    int          mode_left;
    logic [31:0] stall_pattern;

    logic [7:0] base_chars [0:4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T, CHAR_N};

    // Directed text: bases and ignored bytes, empty lines, end of input mid-line
    text_row_t directed_rows [0:24] = '{
        {"@",          1'b0, 1'b0, NO_READ},
        {CHAR_NEWLINE, 1'b0, 1'b0, NO_READ},
        {CHAR_G,       1'b0, 1'b0, NO_READ},
        {CHAR_C,       1'b0, 1'b0, NO_READ},
        {CHAR_A,       1'b0, 1'b0, NO_READ},
        {CHAR_T,       1'b0, 1'b0, NO_READ},
        {CHAR_N,       1'b0, 1'b0, NO_READ},
        {"g",          1'b0, 1'b0, NO_READ},   // lower case is not counted
        {"c",          1'b0, 1'b0, NO_READ},
        {CHAR_CR,      1'b0, 1'b0, NO_READ},
        {8'hFF,        1'b0, 1'b0, NO_READ},
        {8'h00,        1'b0, 1'b0, NO_READ},
        {CHAR_NEWLINE, 1'b0, 1'b1, {16'd2, 16'd5, 17'd26214, 1'b0, 1'b0}},
        {"+",          1'b0, 1'b0, NO_READ},
        {CHAR_NEWLINE, 1'b0, 1'b0, NO_READ},
        {CHAR_NEWLINE, 1'b0, 1'b0, NO_READ},   // empty quality line
        {CHAR_NEWLINE, 1'b0, 1'b0, NO_READ},   // empty header line
        {CHAR_NEWLINE, 1'b0, 1'b1, {16'd0, 16'd0, 17'd0, 1'b1, 1'b0}},
        {CHAR_NEWLINE, 1'b0, 1'b0, NO_READ},
        {CHAR_NEWLINE, 1'b0, 1'b0, NO_READ},
        {CHAR_NEWLINE, 1'b0, 1'b0, NO_READ},
        {CHAR_G,       1'b0, 1'b0, NO_READ},
        {CHAR_C,       1'b1, 1'b1, {16'd2, 16'd2, 17'd65536, 1'b0, 1'b0}},
        {CHAR_A,       1'b1, 1'b0, NO_READ},   // end of input on a header line
        {CHAR_NEWLINE, 1'b1, 1'b0, NO_READ}
    };

    fastq_gc_content_per_read i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned wanted);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t: read %0d: %s is %0d, expected %0d",
                     $time, results_seen, what, got, wanted);
    endtask

    // Summary of the sequence line as it stands
    function automatic read_gc_t read_summary();
        read_gc_t   r;
        logic [63:0] scaled;
        r           = '0;
        r.gc        = seq_gc;
        r.bases     = seq_bases;
        r.saturated = seq_dropped;
        if (seq_bases == '0) begin
            r.no_bases = 1'b1;
        end else begin
            scaled = 64'(seq_gc) << FRACTION_BITS;
            r.frac = FRAC_W'(scaled / 64'(seq_bases));
        end
        return r;
    endfunction

    // Predict the effect of one text byte on line position and tallies
    task automatic track_fastq_byte(input logic [7:0] ch, input logic last,
                                    output logic made, output read_gc_t res);
        logic is_gc;
        logic is_base;
        made = 1'b0;
        res  = '0;
        if (ch == CHAR_NEWLINE) begin
            if (line_pos == LINE_SEQUENCE) begin
                res  = read_summary();
                made = 1'b1;
            end
            line_pos    = line_pos + 2'd1;
            seq_gc      = '0;
            seq_bases   = '0;
            seq_dropped = 1'b0;
        end else if (line_pos == LINE_SEQUENCE) begin
            is_gc   = (ch == CHAR_G) || (ch == CHAR_C);
            is_base = is_gc || (ch == CHAR_A) || (ch == CHAR_T) || (ch == CHAR_N);
            if (is_base) begin
                // a full counter drops the base and marks the read
                if (seq_bases >= TALLY_LIMIT) begin
                    seq_dropped = 1'b1;
                end else begin
                    seq_bases++;
                    if (is_gc)
                        seq_gc++;
                end
            end
            if (last) begin
                res  = read_summary();
                made = 1'b1;
            end
        end
        if (last) begin
            line_pos    = LINE_HEADER;
            seq_gc      = '0;
            seq_bases   = '0;
            seq_dropped = 1'b0;
        end
    endtask

    // Drive one byte in bursts with gaps, wait for the transfer, record the prediction
    task automatic offer_byte(input logic [7:0] ch, input logic last, input logic typed,
                              input read_gc_t want);
        logic     made;
        read_gc_t res;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        track_fastq_byte(ch, last, made, res);
        if (typed)
            pending_reads.insert(pending_reads.size(), want);
        else if (made)
            pending_reads.insert(pending_reads.size(), res);
        bytes_sent++;
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic offer_text(input logic [7:0] ch, input logic last);
        offer_byte(ch, last, 1'b0, NO_READ);
    endtask

    // Stop sending until every predicted read has come out
    task automatic drain_reads();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_reads.size() != 0);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_NEWLINE)
            b = "@";
        return b;
    endfunction

    // One random record; now and then raw noise that breaks the framing
    task automatic send_record();
        int unsigned n;
        int unsigned k;
        int unsigned ending;
        logic [7:0]  ch;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
                ch = ($urandom_range(0, 3) == 0) ? CHAR_NEWLINE : 8'($urandom_range(0, 255));
                offer_text(ch, $urandom_range(0, 15) == 0);
            end
            return;
        end
        // header
        offer_text("@", 1'b0);
        repeat ($urandom_range(0, 6)) offer_text(text_byte(), 1'b0);
        offer_text(CHAR_NEWLINE, 1'b0);
        // sequence: mostly bases, a few long lines, sometimes ended by end of input
        n      = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 24);
        ending = $urandom_range(0, 19);
        for (k = 0; k < n; k++) begin
            ch = ($urandom_range(0, 6) == 0) ? text_byte() : base_chars[$urandom_range(0, 4)];
            offer_text(ch, (ending == 0) && (k == n - 1));
        end
        if (ending == 0 && n != 0)
            return;
        offer_text(CHAR_NEWLINE, ending == 1);
        if (ending == 1)
            return;
        // separator and quality
        offer_text("+", 1'b0);
        repeat ($urandom_range(0, 2)) offer_text(text_byte(), 1'b0);
        offer_text(CHAR_NEWLINE, 1'b0);
        repeat ($urandom_range(0, 8)) offer_text(8'($urandom_range(33, 126)), 1'b0);
        offer_text(CHAR_NEWLINE, $urandom_range(0, 29) == 0);
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.gc        = m_tdata[TALLY_W-1:0];
            seen.bases     = m_tdata[2*TALLY_W-1:TALLY_W];
            seen.frac      = m_tdata[2*TALLY_W+FRAC_W-1:2*TALLY_W];
            seen.no_bases  = m_tuser[0];
            seen.saturated = m_tuser[1];
            results_seen++;
            if (pending_reads.size() == 0) begin
                flag_mismatch("unexpected transfer, gc_count", seen.gc, 0);
            end else begin
                head = pending_reads.pop_front();
                if (seen.gc != head.gc)
                    flag_mismatch("gc_count", seen.gc, head.gc);
                if (seen.bases != head.bases)
                    flag_mismatch("base_count", seen.bases, head.bases);
                if (seen.frac != head.frac)
                    flag_mismatch("gc_fraction", seen.frac, head.frac);
                if (seen.no_bases != head.no_bases)
                    flag_mismatch("no_bases", seen.no_bases, head.no_bases);
                if (seen.saturated != head.saturated)
                    flag_mismatch("count_saturated", seen.saturated, head.saturated);
            end
        end
    end

    // Receiver: changing ready modes, plus one long hold-off to back the block up
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= HOLD_AT_READ) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    ready_mode    = ready_mode_t'($urandom_range(0, 2));
                    mode_left     = $urandom_range(16, 128);
                    stall_pattern = $urandom;
                end
                mode_left--;
                case (ready_mode)
                    READY_ALWAYS: begin
                        m_tready <= 1'b1;
                    end
                    READY_PATTERN: begin
                        m_tready <= stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
                    end
                    default: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // Stimulus
    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        line_pos        = LINE_HEADER;
        seq_gc          = '0;
        seq_bases       = '0;
        seq_dropped     = 1'b0;
        error_count     = 0;
        results_seen    = 0;
        bytes_sent      = 0;
        burst_left      = 0;
        cycle_count     = 0;
        pause_done      = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < 25; i++)
            offer_byte(directed_rows[i].ch, directed_rows[i].last,
                       directed_rows[i].typed, directed_rows[i].want);
        drain_reads();

        // Random records
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            if (!pause_done && bytes_sent - start_bytes >= PAUSE_AFTER) begin
                pause_done = 1'b1;
                drain_reads();
            end
            send_record();
        end
        drain_reads();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
